// ===== hw/rtl/kvmd_pkg.sv =====
// ----------------------------------------------------------------------------
// kvmd_pkg
// Types, constants and register map of the miss descriptor generator.
// ----------------------------------------------------------------------------
package kvmd_pkg;

    localparam int MAX_REQS_DEF   = 64;
    localparam int TOPK_DEF       = 32;
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int PACK_LIMIT     = 2048;

    localparam logic [1:0] OP_TABLE_WRITE = 2'd0;
    localparam logic [1:0] OP_MISS        = 2'd1;
    localparam logic [1:0] OP_END_BATCH   = 2'd2;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_TOTAL = 2'd2;

    localparam logic [2:0] REG_BLOCK_SIZE  = 3'd0;
    localparam logic [2:0] REG_KEY_TB      = 3'd1;
    localparam logic [2:0] REG_VALUE_TB    = 3'd2;
    localparam logic [2:0] REG_KEY_GBASE   = 3'd3;
    localparam logic [2:0] REG_VALUE_GBASE = 3'd4;
    localparam logic [2:0] REG_KEY_LBASE   = 3'd5;
    localparam logic [2:0] REG_VALUE_LBASE = 3'd6;
    localparam logic [2:0] REG_CAPACITY    = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOOKUP,
        ST_READ,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_EMIT_K,
        ST_EMIT_V
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         request_index;
        logic [5:0]         block_number;
        logic signed [31:0] table_value;
        logic [7:0]         entry_position;
        logic signed [31:0] token_position;
        logic signed [31:0] resident_slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [10:0]        pack_pos;
        logic signed [63:0] global_address;
        logic signed [63:0] local_address;
        logic [30:0]        size_bytes;
        logic [12:0]        total_tokens;
        logic               last;
    } t_out_item;

endpackage

// ===== hw/rtl/kvmd_stream_if.sv =====
// ----------------------------------------------------------------------------
// kvmd_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface kvmd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/kvmd_ram.sv =====
// ----------------------------------------------------------------------------
// kvmd_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kvmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/kv_miss_descriptor_generator.sv =====
// ----------------------------------------------------------------------------
// kv_miss_descriptor_generator
// Builds key/value copy descriptors for cache misses from a block table.
// ----------------------------------------------------------------------------
//  channel   | dir | contents
//  in_req    | in  | opcode, request, block, table value, position, token, slot
//  out_res   | out | kind, packed index, addresses, size, total, last
//  apb       | in  | eight config registers at 8*i, 64-bit data
//
// A miss puts out its key descriptor and then its value descriptor, and the next
// request is taken only once the value descriptor has left. The steps are the
// restoring divide of the token by the block size, a table address and a table
// data step, four multiply steps and two emit steps. End of batch puts out its
// total descriptor.
// Reset is synchronous and clears control state and registers; the table
// holds garbage until written. A stalled output holds the block.
module kv_miss_descriptor_generator #(
    parameter int MAX_REQS   = kvmd_pkg::MAX_REQS_DEF,
    parameter int TOPK       = kvmd_pkg::TOPK_DEF,
    parameter int MAX_BLOCKS = kvmd_pkg::MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kvmd_stream_if.sink   in_req,
    kvmd_stream_if.source out_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int DEPTH = MAX_REQS * MAX_BLOCKS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_BLOCKS) > 0 ? $clog2(MAX_BLOCKS) : 1;

    // configuration
    logic [15:0] r_blk_tokens;
    logic [30:0] r_ktb, r_vtb, r_cap;
    logic [63:0] r_kgb, r_vgb, r_klb, r_vlb;
    logic        w_cfg_we;
    logic [2:0]  w_reg;

    assign pready   = 1'b1;
    assign w_reg    = paddr[5:3];
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_tokens <= 16'd16;
            r_ktb <= '0; r_vtb <= '0; r_cap <= 31'd1;
            r_kgb <= '0; r_vgb <= '0; r_klb <= '0; r_vlb <= '0;
        end else if (w_cfg_we && paddr[2:0] == 3'd0) begin
            unique case (w_reg)
                kvmd_pkg::REG_BLOCK_SIZE:  r_blk_tokens <= pwdata[15:0];
                kvmd_pkg::REG_KEY_TB:      r_ktb <= pwdata[30:0];
                kvmd_pkg::REG_VALUE_TB:    r_vtb <= pwdata[30:0];
                kvmd_pkg::REG_KEY_GBASE:   r_kgb <= pwdata;
                kvmd_pkg::REG_VALUE_GBASE: r_vgb <= pwdata;
                kvmd_pkg::REG_KEY_LBASE:   r_klb <= pwdata;
                kvmd_pkg::REG_VALUE_LBASE: r_vlb <= pwdata;
                kvmd_pkg::REG_CAPACITY:    r_cap <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            kvmd_pkg::REG_BLOCK_SIZE:  prdata = {48'd0, r_blk_tokens};
            kvmd_pkg::REG_KEY_TB:      prdata = {33'd0, r_ktb};
            kvmd_pkg::REG_VALUE_TB:    prdata = {33'd0, r_vtb};
            kvmd_pkg::REG_KEY_GBASE:   prdata = r_kgb;
            kvmd_pkg::REG_VALUE_GBASE: prdata = r_vgb;
            kvmd_pkg::REG_KEY_LBASE:   prdata = r_klb;
            kvmd_pkg::REG_VALUE_LBASE: prdata = r_vlb;
            kvmd_pkg::REG_CAPACITY:    prdata = {33'd0, r_cap};
            default:                   prdata = '0;
        endcase
    end

    // datapath state
    kvmd_pkg::t_state r_state, n_state;
    kvmd_pkg::t_in_item w_in;
    logic [5:0]  r_req;
    logic [31:0] r_slot;
    logic [31:0] r_quot;          // dividend shifts out, quotient shifts in
    logic [16:0] r_rem;
    logic [4:0]  r_cnt;
    logic [31:0] r_phys;
    logic [47:0] r_kbs, r_vbs;    // tokens per block * token bytes
    logic [63:0] r_kg, r_vg, r_kl, r_vl;
    logic [37:0] r_row;
    logic [11:0] r_valid_count;
    kvmd_pkg::t_out_item r_out;
    logic        r_out_valid;

    logic        w_accept, w_out_take;
    logic        w_miss_ok;
    logic [16:0] w_rem_sh, w_rem_sub;
    logic        w_ge;
    logic        w_ram_we;
    logic [AW-1:0] w_ram_addr;
    logic [31:0] w_ram_rdata;
    logic        w_blk_ok;

    assign w_in       = in_req.data;
    assign w_out_take = r_out_valid && out_res.ready;
    assign in_req.ready = (r_state == kvmd_pkg::ST_IDLE) && !r_out_valid;
    assign w_accept   = in_req.valid && in_req.ready;
    assign out_res.valid = r_out_valid;
    assign out_res.data  = r_out;

    assign w_miss_ok = ({24'd0, w_in.entry_position} < 32'(TOPK))
        && ({26'd0, w_in.request_index} < 32'(MAX_REQS))
        && !w_in.token_position[31] && !w_in.resident_slot[31]
        && ({1'b0, w_in.resident_slot[30:0]} < {1'b0, r_cap})
        && (r_blk_tokens != 16'd0)
        && (r_valid_count < 12'(kvmd_pkg::PACK_LIMIT));

    assign w_rem_sh  = {r_rem[15:0], r_quot[31]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_blk_tokens};
    assign w_ge      = w_rem_sh >= {1'b0, r_blk_tokens};

    assign w_blk_ok  = r_quot < 32'(MAX_BLOCKS);

    always_comb begin
        w_ram_we   = 1'b0;
        w_ram_addr = AW'(32'(w_in.request_index) * 32'(MAX_BLOCKS)
                         + 32'(w_in.block_number));
        if (r_state == kvmd_pkg::ST_LOOKUP) begin
            w_ram_addr = AW'(32'(r_req) * 32'(MAX_BLOCKS) + 32'(r_quot[BW-1:0]));
        end else if (w_accept && w_in.opcode == kvmd_pkg::OP_TABLE_WRITE
                     && 32'(w_in.request_index) < 32'(MAX_REQS)
                     && 32'(w_in.block_number) < 32'(MAX_BLOCKS)) begin
            w_ram_we = 1'b1;
        end
    end

    kvmd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_in.table_value),
        .o_rdata (w_ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvmd_pkg::ST_IDLE:
                if (w_accept && w_in.opcode == kvmd_pkg::OP_MISS && w_miss_ok) begin
                    n_state = kvmd_pkg::ST_DIV;
                end
            kvmd_pkg::ST_DIV:
                if (r_cnt == 5'd31) n_state = kvmd_pkg::ST_LOOKUP;
            kvmd_pkg::ST_LOOKUP:
                n_state = w_blk_ok ? kvmd_pkg::ST_READ : kvmd_pkg::ST_IDLE;
            kvmd_pkg::ST_READ:
                n_state = w_ram_rdata[31] ? kvmd_pkg::ST_IDLE : kvmd_pkg::ST_M1;
            kvmd_pkg::ST_M1: n_state = kvmd_pkg::ST_M2;
            kvmd_pkg::ST_M2: n_state = kvmd_pkg::ST_M3;
            kvmd_pkg::ST_M3: n_state = kvmd_pkg::ST_M4;
            kvmd_pkg::ST_M4: n_state = kvmd_pkg::ST_EMIT_K;
            kvmd_pkg::ST_EMIT_K:
                if (!r_out_valid) n_state = kvmd_pkg::ST_EMIT_V;
            kvmd_pkg::ST_EMIT_V:
                if (!r_out_valid || w_out_take) n_state = kvmd_pkg::ST_IDLE;
            default: n_state = kvmd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvmd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            kvmd_pkg::ST_IDLE: begin
                r_req  <= w_in.request_index;
                r_slot <= w_in.resident_slot;
                r_quot <= w_in.token_position;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            kvmd_pkg::ST_DIV: begin
                r_rem  <= w_ge ? w_rem_sub : w_rem_sh;
                r_quot <= {r_quot[30:0], w_ge};
                r_cnt  <= r_cnt + 5'd1;
            end
            kvmd_pkg::ST_READ: begin
                r_phys <= w_ram_rdata;
                r_kbs  <= 48'(r_blk_tokens) * 48'(r_ktb);
                r_vbs  <= 48'(r_blk_tokens) * 48'(r_vtb);
                r_row  <= 38'(r_req) * 38'(r_cap) + 38'(r_slot);
            end
            kvmd_pkg::ST_M1: begin
                // phys * (bs*tb), split low and high halves of the 48-bit factor
                r_kg <= 64'(r_phys) * 64'(r_kbs[23:0]);
                r_vg <= 64'(r_phys) * 64'(r_vbs[23:0]);
                r_kl <= r_klb + 64'(r_row[18:0]) * 64'(r_ktb);
                r_vl <= r_vlb + 64'(r_row[18:0]) * 64'(r_vtb);
            end
            kvmd_pkg::ST_M2: begin
                r_kg <= r_kg + ((64'(r_phys) * 64'(r_kbs[47:24])) << 24);
                r_vg <= r_vg + ((64'(r_phys) * 64'(r_vbs[47:24])) << 24);
                r_kl <= r_kl + ((64'(r_row[37:19]) * 64'(r_ktb)) << 19);
                r_vl <= r_vl + ((64'(r_row[37:19]) * 64'(r_vtb)) << 19);
            end
            kvmd_pkg::ST_M3: begin
                r_kg <= r_kg + 64'(r_rem[15:0]) * 64'(r_ktb);
                r_vg <= r_vg + 64'(r_rem[15:0]) * 64'(r_vtb);
            end
            kvmd_pkg::ST_M4: begin
                r_kg <= r_kg + r_kgb;
                r_vg <= r_vg + r_vgb;
            end
            default: ;
        endcase
    end

    // output register and batch count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_valid_count <= '0;
        end else begin
            if (w_out_take) r_out_valid <= 1'b0;
            if (w_accept && w_in.opcode == kvmd_pkg::OP_END_BATCH) begin
                r_out_valid   <= 1'b1;
                r_valid_count <= '0;
            end else if (r_state == kvmd_pkg::ST_EMIT_K && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_state == kvmd_pkg::ST_EMIT_V && (!r_out_valid || w_out_take)) begin
                r_out_valid   <= 1'b1;
                r_valid_count <= r_valid_count + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in.opcode == kvmd_pkg::OP_END_BATCH) begin
            r_out <= '{kind: kvmd_pkg::KIND_TOTAL, pack_pos: '0, global_address: '0,
                       local_address: '0, size_bytes: '0,
                       total_tokens: {r_valid_count, 1'b0}, last: 1'b1};
        end else if (r_state == kvmd_pkg::ST_EMIT_K && !r_out_valid) begin
            r_out <= '{kind: kvmd_pkg::KIND_KEY, pack_pos: r_valid_count[10:0],
                       global_address: r_kg, local_address: r_kl, size_bytes: r_ktb,
                       total_tokens: '0, last: 1'b0};
        end else if (r_state == kvmd_pkg::ST_EMIT_V && (!r_out_valid || w_out_take)) begin
            r_out <= '{kind: kvmd_pkg::KIND_VALUE, pack_pos: r_valid_count[10:0],
                       global_address: r_vg, local_address: r_vl, size_bytes: r_vtb,
                       total_tokens: '0, last: 1'b1};
        end
    end
endmodule

// ===== verif/kv_miss_descriptor_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_miss_descriptor_generator_tb
// Drives table writes, cache misses and batch ends through the request
// channel under random stalls on both sides, reprograms the registers between
// phases, and checks every descriptor and batch total against a predictor.
// ----------------------------------------------------------------------------
module kv_miss_descriptor_generator_tb;
    import kvmd_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int NUM_ITEMS  = 1400;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE     = 80;

    class miss_scoreboard;
        t_out_item          pending[$];
        int                 errors;
        logic signed [31:0] phys_map[MAX_REQS_DEF * MAX_BLOCKS_DEF];
        bit                 mapped[MAX_REQS_DEF * MAX_BLOCKS_DEF];
        logic [11:0]        valid_cnt;
        logic [15:0]        blk_size;
        logic [30:0]        key_tb, val_tb, capacity;
        logic [63:0]        key_gbase, val_gbase, key_lbase, val_lbase;

        function void clear();
            pending.delete();
            errors = 0;
            foreach (mapped[i]) mapped[i] = 0;
            valid_cnt = '0;
            blk_size = 16;
            key_tb = '0;
            val_tb = '0;
            key_gbase = '0;
            val_gbase = '0;
            key_lbase = '0;
            val_lbase = '0;
            capacity = 1;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                REG_BLOCK_SIZE:  blk_size = v[15:0];
                REG_KEY_TB:      key_tb = v[30:0];
                REG_VALUE_TB:    val_tb = v[30:0];
                REG_KEY_GBASE:   key_gbase = v;
                REG_VALUE_GBASE: val_gbase = v;
                REG_KEY_LBASE:   key_lbase = v;
                REG_VALUE_LBASE: val_lbase = v;
                REG_CAPACITY:    capacity = v[30:0];
                default: ;
            endcase
        endfunction

        // Table index a miss looks up, or -1 when it drops before the lookup.
        function int lookup_index(t_in_item it);
            logic [31:0] tok, slot, lb;
            tok = it.token_position;
            slot = it.resident_slot;
            if (it.opcode != OP_MISS || it.entry_position >= TOPK_DEF) return -1;
            if (tok[31] || slot[31]) return -1;
            if (slot >= {1'b0, capacity} || blk_size == 0) return -1;
            lb = tok / blk_size;
            if (lb >= MAX_BLOCKS_DEF) return -1;
            return it.request_index * MAX_BLOCKS_DEF + lb;
        endfunction

        function void note_request(t_in_item it);
            t_out_item   r;
            int          ti;
            logic [63:0] pb, offs, row, bsz, kb, vb;
            r = '0;
            case (it.opcode)
                OP_TABLE_WRITE: begin
                    ti = it.request_index * MAX_BLOCKS_DEF + it.block_number;
                    phys_map[ti] = it.table_value;
                    mapped[ti] = 1;
                end
                OP_END_BATCH: begin
                    r.kind = KIND_TOTAL;
                    r.total_tokens = {valid_cnt, 1'b0};
                    r.last = 1;
                    pending.push_back(r);
                    valid_cnt = '0;
                end
                OP_MISS: begin
                    ti = lookup_index(it);
                    if (ti < 0 || phys_map[ti] < 0 || valid_cnt >= PACK_LIMIT) return;
                    pb = {32'b0, phys_map[ti]};
                    bsz = {48'b0, blk_size};
                    kb = {33'b0, key_tb};
                    vb = {33'b0, val_tb};
                    offs = {32'b0, 32'(it.token_position) % blk_size};
                    row = it.request_index * {33'b0, capacity} + {32'b0, it.resident_slot};
                    r.pack_pos = valid_cnt[10:0];
                    r.kind = KIND_KEY;
                    r.global_address = key_gbase + pb * (bsz * kb) + offs * kb;
                    r.local_address = key_lbase + row * kb;
                    r.size_bytes = key_tb;
                    pending.push_back(r);
                    r.kind = KIND_VALUE;
                    r.global_address = val_gbase + pb * (bsz * vb) + offs * vb;
                    r.local_address = val_lbase + row * vb;
                    r.size_bytes = val_tb;
                    r.last = 1;
                    pending.push_back(r);
                    valid_cnt++;
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected result: kind %0d", got.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("kind", e.kind, got.kind);
            compare("pack_pos", e.pack_pos, got.pack_pos);
            compare("global_address", e.global_address, got.global_address);
            compare("local_address", e.local_address, got.local_address);
            compare("size_bytes", e.size_bytes, got.size_bytes);
            compare("total_tokens", e.total_tokens, got.total_tokens);
            compare("last", e.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;

    kvmd_stream_if #(.T(t_in_item))  in_if ();
    kvmd_stream_if #(.T(t_out_item)) out_if ();

    kv_miss_descriptor_generator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_req  (in_if),
        .out_res (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    miss_scoreboard sb;
    int  progress;
    int  sent;
    bit  no_idle;
    bit  hold_request;
    int  stall_left;
    int  idle_cycles;
    int  last_progress;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1;
        in_if.data <= it;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(it);
        progress++;
        sent++;
    endtask

    // Map the entry a miss would look up before sending the miss.
    task automatic issue(t_in_item it);
        t_in_item w;
        int       ti;
        ti = sb.lookup_index(it);
        if (ti >= 0 && !sb.mapped[ti]) begin
            w = '0;
            w.opcode = OP_TABLE_WRITE;
            w.request_index = ti / MAX_BLOCKS_DEF;
            w.block_number = ti % MAX_BLOCKS_DEF;
            w.table_value = ($urandom_range(0, 3) == 0) ? -32'sd5 : $urandom_range(0, 4000);
            send_request(w);
        end
        send_request(it);
    endtask

    task automatic drain();
        in_if.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        sb.set_reg(idx, v);
        progress++;
    endtask

    function t_in_item make_item(logic [1:0] op, int req, int blk, int tval, int pos,
                                 int tok, int slot);
        t_in_item it;
        it.opcode = op;
        it.request_index = req;
        it.block_number = blk;
        it.table_value = tval;
        it.entry_position = pos;
        it.token_position = tok;
        it.resident_slot = slot;
        return it;
    endfunction

    function t_in_item noise_item();
        return make_item($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom, $urandom_range(0, 255), $urandom, $urandom);
    endfunction

    function t_in_item good_miss(int req, int nblk);
        int tok;
        if (sb.blk_size == 0) tok = $urandom_range(0, 1000);
        else tok = $urandom_range(0, nblk - 1) * sb.blk_size + ($urandom % sb.blk_size);
        return make_item(OP_MISS, req, $urandom_range(0, 63), $urandom,
                         $urandom_range(0, TOPK_DEF - 1), tok, $urandom % sb.capacity);
    endfunction

    // Map a few blocks of one request, miss on them with some noise, and sometimes end the batch.
    task automatic run_burst();
        int req, nblk, k, tv;
        req = $urandom_range(0, 63);
        nblk = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 6);
        if (nblk == 64 && sb.blk_size > 0 && sb.blk_size * 64 > 32'h7fff_ffff) nblk = 4;
        for (int b = 0; b < nblk; b++) begin
            if (nblk == 64 && sb.mapped[req * MAX_BLOCKS_DEF + b] && $urandom_range(0, 1)) continue;
            tv = ($urandom_range(0, 7) == 0) ? int'($urandom | 32'h8000_0000)
                                              : int'($urandom_range(0, 1) ? $urandom >> 1
                                                                          : $urandom_range(0, 255));
            send_request(make_item(OP_TABLE_WRITE, req, b, tv, $urandom_range(0, 255),
                                   $urandom, $urandom));
        end
        k = $urandom_range(1, 12);
        repeat (k) begin
            if ($urandom_range(0, 7) == 0) issue(noise_item());
            else issue(good_miss(req, (nblk == 64) ? 8 : nblk));
        end
        if ($urandom_range(0, 3) == 0)
            send_request(make_item(OP_END_BATCH, $urandom_range(0, 63), 0, 0, 0, 0, 0));
    endtask

    function logic [63:0] pick_base();
        case ($urandom_range(0, 3))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function logic [63:0] pick_tb();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 64'h7fff_ffff;
            2: return $urandom_range(1, 512);
            default: return $urandom >> 1;
        endcase
    endfunction

    task automatic program_phase(int sel);
        logic [63:0] bs, cap;
        case (sel % 5)
            0: bs = 1;
            1: bs = 65535;
            2: bs = 0;
            default: bs = $urandom_range(1, 300);
        endcase
        case ($urandom_range(0, 2))
            0: cap = 1;
            1: cap = 64'h7fff_ffff;
            default: cap = $urandom_range(1, 64);
        endcase
        drain();
        write_reg(REG_BLOCK_SIZE, bs);
        write_reg(REG_KEY_TB, pick_tb());
        write_reg(REG_VALUE_TB, pick_tb());
        write_reg(REG_KEY_GBASE, pick_base());
        write_reg(REG_VALUE_GBASE, pick_base());
        write_reg(REG_KEY_LBASE, pick_base());
        write_reg(REG_VALUE_LBASE, pick_base());
        write_reg(REG_CAPACITY, cap);
    endtask

    // Receiver: random ready, with long holds requested from the main thread.
    always @(posedge i_clk) begin
        int r;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.data);
                progress++;
            end
            if (hold_request) begin
                hold_request = 0;
                stall_left = LONG_HOLD;
            end
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 0;
            end else if (no_idle || r < 70) begin
                out_if.ready <= 1;
            end else if (r < 96) begin
                out_if.ready <= 0;
            end else begin
                stall_left = $urandom_range(10, 40);
                out_if.ready <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (progress != last_progress) begin
            last_progress = progress;
            idle_cycles = 0;
        end else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int phase;
        sb = new();
        sb.clear();
        progress = 0;
        last_progress = 0;
        idle_cycles = 0;
        sent = 0;
        no_idle = 0;
        hold_request = 0;
        stall_left = 0;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 0;
        in_if.data = '0;
        out_if.ready = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_reg(REG_BLOCK_SIZE, 4);
        write_reg(REG_KEY_TB, 8);
        write_reg(REG_VALUE_TB, 64'h7fff_ffff);
        write_reg(REG_KEY_GBASE, 64'h7fff_ffff_ffff_fff0);
        write_reg(REG_VALUE_GBASE, 64'h8000_0000_0000_0000);
        write_reg(REG_KEY_LBASE, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_VALUE_LBASE, 64'h1000);
        write_reg(REG_CAPACITY, 4);

        // Directed: table extremes, drops on entry, token, slot, block and table value, empty and non-empty batch ends.
        send_request(make_item(OP_TABLE_WRITE, 63, 63, 32'h7fff_ffff, 255, -1, -1));
        send_request(make_item(OP_TABLE_WRITE, 0, 0, 0, 0, 0, 0));
        send_request(make_item(OP_TABLE_WRITE, 0, 1, 32'h8000_0000, 0, 0, 0));
        send_request(make_item(OP_TABLE_WRITE, 1, 2, 5, 0, 0, 0));
        send_request(make_item(2'd3, 63, 63, -1, 255, -1, -1));
        send_request(make_item(OP_MISS, 0, 0, 0, 0, 0, 0));
        send_request(make_item(OP_MISS, 0, 63, -1, 31, 3, 3));
        send_request(make_item(OP_MISS, 0, 0, 0, 32, 1, 0));
        send_request(make_item(OP_MISS, 0, 0, 0, 255, 1, 0));
        send_request(make_item(OP_MISS, 0, 0, 0, 1, -1, 0));
        send_request(make_item(OP_MISS, 0, 0, 0, 1, 1, 32'h8000_0000));
        send_request(make_item(OP_MISS, 0, 0, 0, 1, 1, 4));
        send_request(make_item(OP_MISS, 0, 0, 0, 1, 256, 0));
        send_request(make_item(OP_MISS, 0, 0, 0, 1, 32'h7fff_ffff, 0));
        send_request(make_item(OP_MISS, 0, 0, 0, 2, 5, 1));
        send_request(make_item(OP_MISS, 63, 0, 0, 7, 253, 2));
        send_request(make_item(OP_MISS, 1, 0, 0, 9, 9, 1));
        send_request(make_item(OP_END_BATCH, 0, 0, 0, 0, 0, 0));
        send_request(make_item(OP_END_BATCH, 63, 63, -1, 255, -1, -1));
        send_request(make_item(OP_TABLE_WRITE, 63, 63, 0, 0, 0, 0));
        send_request(make_item(OP_MISS, 63, 0, 0, 31, 255, 3));
        send_request(make_item(OP_END_BATCH, 0, 0, 0, 0, 0, 0));

        phase = 0;
        while (sent < NUM_ITEMS) begin
            program_phase(phase);
            no_idle = (phase % 4 == 3);
            if (phase == 1) hold_request = 1;
            for (int b = 0; b < 12 && sent < NUM_ITEMS; b++) run_burst();
            send_request(make_item(OP_END_BATCH, 0, 0, 0, 0, 0, 0));
            phase++;
        end
        no_idle = 0;

        in_if.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
